[sv/ftma_pkg.sv]
package ftma_pkg;

    // Field widths fixed by the interface.
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 7;

    // Defaults for the top-level parameters.
    localparam int MAX_WINDOW_DEF    = 64;
    localparam int FRACTION_BITS_DEF = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } ftma_state_t;

endpackage

[sv/ftma_ram.sv]
module ftma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ftma_serial_div.sv]
module ftma_serial_div #(
    parameter int DVD_W = 46,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    // Restoring division: the dividend shifts out of the top of dq_reg one
    // bit per cycle while quotient bits shift in at the bottom.
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dq_reg,  dq_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[DVD_W-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        diff      = trial - {1'b0, dvs_reg};
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[sv/frame_time_moving_average_unit.sv]
// Frame time moving average.
// Each transfer on the input channel (in_valid, in_stall, time_stamp) carries
// a free-running tick count. The block takes the wrapped difference from the
// previous stamp as the frame duration and returns, for every input
// transfer, one output transfer (out_valid, out_stall) carrying that
// duration and the mean of the last window_len durations with FRACTION_BITS
// fraction bits. Until the window has filled, the mean covers every sample.
// Writing window_len (window_len_we high for one cycle) restarts the warm-up.
// An item passes from its input transfer through the update state and the
// bit-serial divider to the output register. The block takes no new item
// before the last result has been loaded, because the input is only released
// in the cycle after the result has been loaded. The divider produces one
// quotient bit per cycle over the DIV_W-bit scaled sum.
// After reset the window length is 1, the previous stamp and the running sum
// are zero, and the duration ring is empty. When the receiver stalls, the
// result waits in the output register; the next input item is still taken
// and worked on, and its result waits until the register has been emptied.
module frame_time_moving_average_unit
    import ftma_pkg::*;
#(
    parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int AVG_W         = STAMP_W + FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               window_len_we,
    input  logic [CFG_W-1:0]   window_len,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [STAMP_W-1:0] time_stamp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [AVG_W-1:0]   avg_frame_ticks,
    output logic [STAMP_W-1:0] last_frame_ticks
);

    // Width of the sample count and of the effective window (holds MAX_WINDOW).
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    // Width of a ring index.
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    // The running sum holds up to MAX_WINDOW full-range durations.
    localparam int SUM_W = STAMP_W + $clog2(MAX_WINDOW);
    // The scaled sum that the divider works through.
    localparam int DIV_W = SUM_W + FRACTION_BITS;
    localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    ftma_state_t        state_reg, state_next;
    logic [STAMP_W-1:0] prev_reg;
    logic [STAMP_W-1:0] dur_reg;
    logic [PTR_W-1:0]   slot_reg;
    logic               warm_reg;
    logic [CNT_W-1:0]   win_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]   avg_reg;
    logic [STAMP_W-1:0] last_reg;

    logic               accept;
    logic [PTR_W-1:0]   slot;
    logic [CNT_W-1:0]   win_eff;
    logic [CNT_W-1:0]   next_index;
    logic               ram_we;
    logic [STAMP_W-1:0] ram_rdata;
    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic               load_out;

    // A window length of zero counts as one; anything above the ring depth
    // saturates at the ring depth.
    always_comb
    begin
        if (window_len == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (CMP_W'(window_len) > CMP_W'(MAX_WINDOW))
        begin
            win_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CNT_W'(CMP_W'(window_len));
        end
    end

    assign accept = in_valid && !in_stall;

    // The pointer may sit beyond a window that has since shrunk, in which
    // case the slot wraps to the start of the ring.
    assign slot = (CNT_W'(ptr_reg) >= win_reg) ? '0 : ptr_reg;

    // The ring is read at the slot when the item is taken, so the entry that
    // leaves the window is ready in the following update cycle.
    ftma_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (MAX_WINDOW),
        .AW    (PTR_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (dur_reg),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign next_index = CNT_W'(slot_reg) + CNT_W'(1);

    // Control sequence: the update state, then the divider runs, then the
    // result is moved to the output register once that register is free.
    always_comb
    begin
        state_next     = state_reg;
        in_stall       = (state_reg != ST_IDLE);
        ram_we         = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ram_we    = 1'b1;
                div_start = 1'b1;
                if (warm_reg)
                begin
                    sum_next   = sum_reg + SUM_W'(dur_reg);
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    sum_next = sum_reg - SUM_W'(ram_rdata) + SUM_W'(dur_reg);
                end
                ptr_next   = (next_index >= win_reg) ? '0 : PTR_W'(next_index);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // A configuration write restarts the warm-up.
        if (window_len_we)
        begin
            count_next = '0;
            ptr_next   = '0;
            sum_next   = '0;
        end
    end

    ftma_serial_div #(
        .DVD_W (DIV_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIV_W'(sum_next) << FRACTION_BITS),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            win_reg       <= CNT_W'(1);
            count_reg     <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                prev_reg <= time_stamp;
            end
            if (window_len_we)
            begin
                win_reg <= win_eff;
            end
        end
    end

    // Per-item payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dur_reg  <= time_stamp - prev_reg;
            slot_reg <= slot;
            warm_reg <= (count_reg < win_reg);
        end
        if (load_out)
        begin
            avg_reg  <= div_quot[AVG_W-1:0];
            last_reg <= dur_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign avg_frame_ticks  = avg_reg;
    assign last_frame_ticks = last_reg;

endmodule
